>>> src/aes_cbc_pkg.sv
// Shared types, tables and round functions for the AES-128 CBC cipher.
package aes_cbc_pkg;

  localparam int unsigned ROUNDS = 10;
  localparam int unsigned RndW = $clog2(ROUNDS + 1);

  typedef enum logic [1:0] {
    StIdle,
    StSub,
    StMix,
    StOut
  } aes_cbc_state_e;

  typedef enum logic [2:0] {
    RegKeyHigh = 3'd0,
    RegKeyLow  = 3'd1,
    RegIvHigh  = 3'd2,
    RegIvLow   = 3'd3,
    RegMode    = 3'd4
  } aes_cbc_reg_e;

  localparam logic [2047:0] SBOX = {
    128'h637C777BF26B6FC53001672BFED7AB76, 128'hCA82C97DFA5947F0ADD4A2AF9CA472C0,
    128'hB7FD9326363FF7CC34A5E5F171D83115, 128'h04C723C31896059A071280E2EB27B275,
    128'h09832C1A1B6E5AA0523BD6B329E32F84, 128'h53D100ED20FCB15B6ACBBE394A4C58CF,
    128'hD0EFAAFB434D338545F9027F503C9FA8, 128'h51A3408F929D38F5BCB6DA2110FFF3D2,
    128'hCD0C13EC5F974417C4A77E3D645D1973, 128'h60814FDC222A908846EEB814DE5E0BDB,
    128'hE0323A0A4906245CC2D3AC629195E479, 128'hE7C8376D8DD54EA96C56F4EA657AAE08,
    128'hBA78252E1CA6B4C6E8DD741F4BBD8B8A, 128'h703EB5664803F60E613557B986C11D9E,
    128'hE1F8981169D98E949B1E87E9CE5528DF, 128'h8CA1890DBFE6426841992D0FB054BB16
  };

  localparam logic [2047:0] INV_SBOX = {
    128'h52096AD53036A538BF40A39E81F3D7FB, 128'h7CE339829B2FFF87348E4344C4DEE9CB,
    128'h547B9432A6C2233DEE4C950B42FAC34E, 128'h082EA16628D924B2765BA2496D8BD125,
    128'h72F8F66486689816D4A45CCC5D65B692, 128'h6C704850FDEDB9DA5E154657A78D9D84,
    128'h90D8AB008CBCD30AF7E45805B8B34506, 128'hD02C1E8FCA3F0F02C1AFBD0301138A6B,
    128'h3A9111414F67DCEA97F2CFCEF0B4E673, 128'h96AC7422E7AD3585E2F937E81C75DF6E,
    128'h47F11A711D29C5896FB7620EAA18BE1B, 128'hFC563E4BC6D279209ADBC0FE78CD5AF4,
    128'h1FDDA8338807C731B11210592780EC5F, 128'h60517FA919B54A0D2DE57A9F93C99CEF,
    128'hA0E03B4DAE2AF5B0C8EBBB3C83539961, 128'h172B047EBA77D626E169146355210C7D
  };

  function automatic logic [7:0] sub_byte(input logic [7:0] x, input logic inv);
    logic [10:0] pos;
    pos = {~x, 3'b111};
    return inv ? INV_SBOX[pos -: 8] : SBOX[pos -: 8];
  endfunction

  function automatic logic [7:0] rcon(input logic [RndW-1:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1B;
      4'd10:   v = 8'h36;
      default: v = 8'h8D;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  // byte i of the state sits at column i/4, row i%4; byte 0 is the MSB
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int src;
    int dst;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          src = r + 4 * c;
          dst = r + 4 * ((c + r) & 3);
        end else begin
          src = r + 4 * ((c + r) & 3);
          dst = r + 4 * c;
        end
        t[127 - 8 * dst -: 8] = s[127 - 8 * src -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
    logic [7:0] a [4];
    logic [7:0] m1 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m4 [4];
    logic [31:0] o;
    for (int k = 0; k < 4; k++) begin
      a[k] = col[31 - 8 * k -: 8];
      m1[k] = xtime(a[k]);
      m2[k] = xtime(m1[k]);
      m3[k] = xtime(m2[k]);
      // forward: m1 = 2a, m4 = 3a; inverse: m1 = 0E, m2 = 0B, m3 = 0D, m4 = 09
      if (inv) begin
        m4[k] = m3[k] ^ a[k];
        m1[k] = m3[k] ^ m2[k] ^ m1[k];
        m2[k] = m4[k] ^ xtime(a[k]);
        m3[k] = m4[k] ^ xtime(xtime(a[k]));
      end else begin
        m4[k] = m1[k] ^ a[k];
      end
    end
    for (int r = 0; r < 4; r++) begin
      if (inv) begin
        o[31 - 8 * r -: 8] = m1[r] ^ m2[(r + 1) & 3] ^ m3[(r + 2) & 3] ^ m4[(r + 3) & 3];
      end else begin
        o[31 - 8 * r -: 8] = m1[r] ^ m4[(r + 1) & 3] ^ a[(r + 2) & 3] ^ a[(r + 3) & 3];
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      t[127 - 32 * c -: 32] = mix_col(s[127 - 32 * c -: 32], inv);
    end
    return t;
  endfunction

endpackage

>>> src/aes_cbc_if.sv
// Valid/ready channel interfaces for input and result blocks.
interface aes_cbc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_high;
  logic [63:0] data_low;
  logic        first_block;
  modport source (output valid, data_high, data_low, first_block, input ready);
  modport sink (input valid, data_high, data_low, first_block, output ready);
endinterface

interface aes_cbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_high;
  logic [63:0] out_low;
  modport source (output valid, out_high, out_low, input ready);
  modport sink (input valid, out_high, out_low, output ready);
endinterface

>>> src/aes128_cbc_cipher.sv
// AES-128 CBC cipher top level, byte-serial round engine and key expander.
//
// Usage: blocks enter on in_i (valid/ready); each request gives one result
// on out_o. Key, IV and mode are written through cfg_we_i/cfg_idx_i/cfg_data_i
// and the user must see that they are written only while the block is idle:
// the block does not enforce it. Indexes 5 to 7 are ignored. first_block
// reloads the chaining value from the IV.
// The accept cycle loads the block and adds the first round key; each round
// then passes the state through the single S-box (one byte a cycle), then
// does row shift, column mix (skipped in the last round) and key add in
// StMix; the output state StOut then writes the result register. One block
// is in flight at a time and the engine returns to idle before the next
// accept, so a new block is taken only once the last one has left StOut.
// Key expansion runs after reset and after every write of a key register:
// a load step, then the ten round keys in turn; in_i.ready stays low
// meanwhile. Reset clears key, IV, mode and chain value to zero and expands
// the zero key. A result that is not taken holds in the output register; the
// engine waits in its output state until the register frees.
module aes128_cbc_cipher (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [63:0]         cfg_data_i,
  aes_cbc_in_if.sink          in_i,
  aes_cbc_out_if.source       out_o
);

  localparam int unsigned RW = aes_cbc_pkg::RndW;
  localparam logic [RW-1:0] LastRnd = RW'(aes_cbc_pkg::ROUNDS);

  logic [127:0] key_q, iv_q;
  logic         mode_q;

  logic [127:0] keys_q [aes_cbc_pkg::ROUNDS + 1];

  // key expander
  logic          kload_q, kload_d;
  logic          krun_q, krun_d;
  logic [RW-1:0] krnd_q, krnd_d;
  logic [1:0]    kcnt_q, kcnt_d;
  logic [23:0]   tw_q, tw_d;
  logic [127:0]  rk_q, rk_d;
  logic          kwe;
  logic [RW-1:0] kwaddr;
  logic [127:0]  kwdata;
  logic [31:0]   rotw, tword, w0, w1, w2, w3;
  logic [7:0]    ksb;
  logic          kbusy;

  // datapath
  aes_cbc_pkg::aes_cbc_state_e state_q, state_d;
  logic [127:0] s_q, s_d;
  logic [127:0] chain_q, chain_d;
  logic [127:0] ct_q, ct_d;
  logic         dmode_q, dmode_d;
  logic [RW-1:0] rnd_q, rnd_d;
  logic [3:0]   bcnt_q, bcnt_d;
  logic         ovalid_q, ovalid_d;
  logic [127:0] odata_q, odata_d;
  logic [RW-1:0] kidx;
  logic [127:0] rkey, chain_use, t;
  logic          accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      iv_q   <= '0;
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aes_cbc_pkg::RegKeyHigh: key_q[127:64] <= cfg_data_i;
        aes_cbc_pkg::RegKeyLow:  key_q[63:0]   <= cfg_data_i;
        aes_cbc_pkg::RegIvHigh:  iv_q[127:64]  <= cfg_data_i;
        aes_cbc_pkg::RegIvLow:   iv_q[63:0]    <= cfg_data_i;
        aes_cbc_pkg::RegMode:    mode_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- key expansion, one S-box byte per cycle ----------------
  assign w0    = rk_q[127:96];
  assign w1    = rk_q[95:64];
  assign w2    = rk_q[63:32];
  assign w3    = rk_q[31:0];
  assign rotw  = {w3[23:0], w3[31:24]};
  assign ksb   = aes_cbc_pkg::sub_byte(rotw[31 - {kcnt_q, 3'b000} -: 8], 1'b0);
  assign tword = {tw_q, ksb} ^ {aes_cbc_pkg::rcon(krnd_q), 24'h0};
  assign kbusy = kload_q | krun_q;

  always_comb begin
    kload_d = cfg_we_i && (cfg_idx_i == aes_cbc_pkg::RegKeyHigh ||
                           cfg_idx_i == aes_cbc_pkg::RegKeyLow);
    krun_d  = krun_q;
    krnd_d  = krnd_q;
    kcnt_d  = kcnt_q;
    tw_d    = tw_q;
    rk_d    = rk_q;
    kwe     = 1'b0;
    kwaddr  = krnd_q;
    kwdata  = rk_q;
    if (kload_q) begin
      rk_d   = key_q;
      kwe    = 1'b1;
      kwaddr = '0;
      kwdata = key_q;
      krun_d = 1'b1;
      krnd_d = RW'(1);
      kcnt_d = '0;
    end else if (krun_q) begin
      tw_d   = {tw_q[15:0], ksb};
      kcnt_d = kcnt_q + 2'd1;
      if (kcnt_q == 2'd3) begin
        rk_d[127:96] = w0 ^ tword;
        rk_d[95:64]  = w1 ^ w0 ^ tword;
        rk_d[63:32]  = w2 ^ w1 ^ w0 ^ tword;
        rk_d[31:0]   = w3 ^ w2 ^ w1 ^ w0 ^ tword;
        kwe    = 1'b1;
        kwdata = rk_d;
        krnd_d = krnd_q + RW'(1);
        if (krnd_q == LastRnd) begin
          krun_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kload_q <= 1'b1;
      krun_q  <= 1'b0;
      krnd_q  <= '0;
      kcnt_q  <= '0;
    end else begin
      kload_q <= kload_d;
      krun_q  <= krun_d;
      krnd_q  <= krnd_d;
      kcnt_q  <= kcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tw_q <= tw_d;
    rk_q <= rk_d;
    if (kwe) begin
      keys_q[kwaddr] <= kwdata;
    end
  end

  // ---------------- cipher datapath ----------------
  assign in_i.ready   = (state_q == aes_cbc_pkg::StIdle) && !kbusy;
  assign accept       = in_i.valid && in_i.ready;
  assign out_o.valid    = ovalid_q;
  assign out_o.out_high = odata_q[127:64];
  assign out_o.out_low  = odata_q[63:0];

  always_comb begin
    if (state_q == aes_cbc_pkg::StIdle) begin
      kidx = mode_q ? LastRnd : '0;
    end else begin
      kidx = dmode_q ? LastRnd - rnd_q : rnd_q;
    end
  end
  assign rkey      = keys_q[kidx];
  assign chain_use = in_i.first_block ? iv_q : chain_q;

  always_comb begin
    state_d  = state_q;
    s_d      = s_q;
    chain_d  = chain_q;
    ct_d     = ct_q;
    dmode_d  = dmode_q;
    rnd_d    = rnd_q;
    bcnt_d   = bcnt_q;
    odata_d  = odata_q;
    ovalid_d = ovalid_q && !out_o.ready;
    t        = '0;
    unique case (state_q)
      aes_cbc_pkg::StIdle: begin
        if (accept) begin
          chain_d = chain_use;
          ct_d    = {in_i.data_high, in_i.data_low};
          dmode_d = mode_q;
          if (mode_q) begin
            s_d = {in_i.data_high, in_i.data_low} ^ rkey;
          end else begin
            s_d = {in_i.data_high, in_i.data_low} ^ chain_use ^ rkey;
          end
          rnd_d   = RW'(1);
          bcnt_d  = '0;
          state_d = aes_cbc_pkg::StSub;
        end
      end
      aes_cbc_pkg::StSub: begin
        s_d    = {s_q[119:0], aes_cbc_pkg::sub_byte(s_q[127:120], dmode_q)};
        bcnt_d = bcnt_q + 4'd1;
        if (bcnt_q == 4'd15) begin
          state_d = aes_cbc_pkg::StMix;
        end
      end
      aes_cbc_pkg::StMix: begin
        if (dmode_q) begin
          t = aes_cbc_pkg::shift_rows(s_q, 1'b1) ^ rkey;
          s_d = (rnd_q == LastRnd) ? t : aes_cbc_pkg::mix_columns(t, 1'b1);
        end else begin
          t = aes_cbc_pkg::shift_rows(s_q, 1'b0);
          if (rnd_q != LastRnd) begin
            t = aes_cbc_pkg::mix_columns(t, 1'b0);
          end
          s_d = t ^ rkey;
        end
        rnd_d   = rnd_q + RW'(1);
        state_d = (rnd_q == LastRnd) ? aes_cbc_pkg::StOut : aes_cbc_pkg::StSub;
      end
      aes_cbc_pkg::StOut: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          odata_d  = dmode_q ? (s_q ^ chain_q) : s_q;
          chain_d  = dmode_q ? ct_q : s_q;
          state_d  = aes_cbc_pkg::StIdle;
        end
      end
      default: state_d = aes_cbc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= aes_cbc_pkg::StIdle;
      chain_q  <= '0;
      ovalid_q <= 1'b0;
      rnd_q    <= '0;
      bcnt_q   <= '0;
      dmode_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      chain_q  <= chain_d;
      ovalid_q <= ovalid_d;
      rnd_q    <= rnd_d;
      bcnt_q   <= bcnt_d;
      dmode_q  <= dmode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    ct_q    <= ct_d;
    odata_q <= odata_d;
  end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the AES-128 CBC cipher: directed table, then random messages.
`timescale 1ns / 100ps

module tb_top;

  typedef logic [0:15][7:0] blk_t;   // byte 0 is the most significant byte

  typedef enum logic {RowCfg, RowBlock} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        first;
    logic        known;
    logic [127:0] want;
  } row_t;

  localparam logic [2:0] RegUnused = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  aes_cbc_in_if  in_ch ();
  aes_cbc_out_if out_ch ();

  aes128_cbc_cipher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // cipher state mirror
  logic [7:0]   fwd_box [256];
  logic [7:0]   inv_box [256];
  logic [127:0] sched [11];
  logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
  logic         decrypt;
  logic [127:0] chain;

  logic [127:0] blocks_due [$];
  row_t         rows [$];
  int           errors = 0;
  int           tx_idle = 0;
  int           rx_idle = 0;
  logic         rx_hold = 1'b0;
  logic         hold_req = 1'b0;

  function automatic logic [7:0] gmul(logic [7:0] x, logic [7:0] y);
    logic [7:0] r;
    r = '0;
    while (y != 0) begin
      if (y[0]) r ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
      y = y >> 1;
    end
    return r;
  endfunction

  // S-box from the field inverse plus the affine map
  task automatic build_boxes();
    logic [7:0] b, s;
    for (int x = 0; x < 256; x++) begin
      b = 8'h00;
      for (int y = 1; y < 256; y++) begin
        if (gmul(x[7:0], y[7:0]) == 8'h01) b = y[7:0];
      end
      s = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]} ^ 8'h63;
      fwd_box[x] = s;
      inv_box[s] = x[7:0];
    end
  endtask

  task automatic expand_schedule();
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    w[0] = key_hi[63:32]; w[1] = key_hi[31:0];
    w[2] = key_lo[63:32]; w[3] = key_lo[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]};
        t ^= {rc, 24'h0};
        rc = gmul(rc, 8'h02);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) sched[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  function automatic blk_t round_step(blk_t s, bit inv, bit mix, int rk);
    blk_t t;
    logic [7:0] fm [4];
    logic [7:0] im [4];
    logic [7:0] a [4];
    fm = '{8'h02, 8'h03, 8'h01, 8'h01};
    im = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
    for (int i = 0; i < 16; i++) s[i] = inv ? inv_box[s[i]] : fwd_box[s[i]];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) t[r + 4*((c + r) & 3)] = s[r + 4*c];
        else t[r + 4*c] = s[r + 4*((c + r) & 3)];
      end
    end
    // decrypt adds the key before the inverse column mix
    if (inv) t = t ^ blk_t'(sched[rk]);
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 4; k++) a[k] = t[4*c + k];
        for (int r = 0; r < 4; r++) begin
          t[4*c + r] = 8'h00;
          for (int k = 0; k < 4; k++)
            t[4*c + r] ^= gmul(a[k], inv ? im[(k - r + 4) & 3] : fm[(k - r + 4) & 3]);
        end
      end
    end
    if (!inv) t = t ^ blk_t'(sched[rk]);
    return t;
  endfunction

  function automatic logic [127:0] cbc_block(logic [127:0] din, logic first);
    blk_t s;
    if (first) chain = {iv_hi, iv_lo};
    if (!decrypt) begin
      s = blk_t'(din ^ chain ^ sched[0]);
      for (int r = 1; r <= 10; r++) s = round_step(s, 1'b0, r != 10, r);
      chain = s;
      return s;
    end
    s = blk_t'(din ^ sched[10]);
    for (int r = 9; r >= 0; r--) s = round_step(s, 1'b1, r != 0, r);
    s = s ^ blk_t'(chain);
    chain = din;
    return s;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // result side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk_i) begin
    logic [127:0] want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (blocks_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h%h", out_ch.out_high, out_ch.out_low);
      end else begin
        want = blocks_due.pop_front();
        if (out_ch.out_high !== want[127:64] || out_ch.out_low !== want[63:0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %h_%h got %h_%h", want[127:64], want[63:0],
                     out_ch.out_high, out_ch.out_low);
        end
      end
    end
  end

  // long receiver hold-off so the engine backs up into the input
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (800) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (blocks_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // cfg_we_i drops after each write so back-to-back writes never collide
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      aes_cbc_pkg::RegKeyHigh: begin key_hi = val; expand_schedule(); end
      aes_cbc_pkg::RegKeyLow:  begin key_lo = val; expand_schedule(); end
      aes_cbc_pkg::RegIvHigh:  iv_hi = val;
      aes_cbc_pkg::RegIvLow:   iv_lo = val;
      aes_cbc_pkg::RegMode:    decrypt = val[0];
      default: ;
    endcase
  endtask

  // returns the predicted block; called at a clock edge
  task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic first,
                            output logic [127:0] got);
    if ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_high   <= hi;
    in_ch.data_low    <= lo;
    in_ch.first_block <= first;
    do @(posedge clk_i); while (!in_ch.ready);
    got = cbc_block({hi, lo}, first);
    blocks_due.push_back(got);
  endtask

  task automatic add_cfg(logic [2:0] idx, logic [63:0] val);
    rows.push_back('{RowCfg, idx, val, 64'h0, 1'b0, 1'b0, 128'h0});
  endtask

  task automatic add_blk(logic [63:0] hi, logic [63:0] lo, logic first, logic known,
                         logic [127:0] want);
    rows.push_back('{RowBlock, RegUnused, hi, lo, first, known, want});
  endtask

  initial begin
    logic [127:0] got;
    int           msg_len;
    in_ch.valid       <= 1'b0;
    in_ch.data_high   <= '0;
    in_ch.data_low    <= '0;
    in_ch.first_block <= 1'b0;
    build_boxes();
    key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
    decrypt = 1'b0;
    chain = '0;
    expand_schedule();

    // no message start right after reset: chains on zero
    add_blk('0, '0, 1'b0, 1'b0, '0);
    add_blk('1, '1, 1'b0, 1'b0, '0);
    add_cfg(aes_cbc_pkg::RegKeyHigh, 64'h0001020304050607);
    add_cfg(aes_cbc_pkg::RegKeyLow, 64'h08090A0B0C0D0E0F);
    add_blk(64'h0011223344556677, 64'h8899AABBCCDDEEFF, 1'b1, 1'b1,
            128'h69C4E0D86A7B0430D8CDB78070B4C55A);
    add_cfg(aes_cbc_pkg::RegMode, 64'h1);
    add_blk(64'h69C4E0D86A7B0430, 64'hD8CDB78070B4C55A, 1'b1, 1'b1,
            128'h00112233445566778899AABBCCDDEEFF);
    // mode bits above bit 0 are dropped
    add_cfg(aes_cbc_pkg::RegMode, 64'hFFFF_FFFF_FFFF_FFFE);
    add_cfg(aes_cbc_pkg::RegIvHigh, '1);
    add_cfg(aes_cbc_pkg::RegIvLow, '1);
    add_blk('1, '0, 1'b0, 1'b0, '0);    // new IV not used yet
    add_blk('0, '1, 1'b1, 1'b0, '0);
    add_cfg(aes_cbc_pkg::RegKeyHigh, '1);   // key change inside a message
    add_blk(64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 1'b0, 1'b0, '0);
    add_cfg(aes_cbc_pkg::RegMode, 64'h1);   // direction change inside a message
    add_blk('1, '1, 1'b0, 1'b0, '0);
    add_cfg(3'd5, '1);                  // out-of-range indexes are ignored
    add_cfg(RegUnused, 64'h5555_AAAA_5555_AAAA);
    add_blk('0, '0, 1'b0, 1'b0, '0);
    add_cfg(aes_cbc_pkg::RegKeyLow, '1);
    add_blk('0, '0, 1'b1, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == RowCfg) begin
        drain();
        write_reg(rows[i].idx, rows[i].hi);
      end else begin
        send_block(rows[i].hi, rows[i].lo, rows[i].first, got);
        if (rows[i].known && got !== rows[i].want) begin
          errors++;
          if (errors <= 10) $display("model disagrees with table: %h vs %h", got, rows[i].want);
        end
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle = (phase == 0) ? 17 : (phase == 1) ? 67 : 0;
      rx_idle = (phase == 0) ? 67 : (phase == 1) ? 17 : 0;
      if (phase == 2) hold_req = 1'b1;
      for (int n = 0; n < 560; ) begin
        if ($urandom_range(3) == 0) begin
          drain();
          repeat ($urandom_range(1, 3)) write_reg(3'($urandom_range(7)), rand_word());
        end
        msg_len = $urandom_range(1, 8);
        for (int b = 0; b < msg_len; b++) begin
          // mostly well-formed messages; a few stray message-start flags
          send_block(rand_word(), rand_word(),
                     (b == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0), got);
          n++;
        end
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
